FILE: rtl/qbc_pkg.sv
package qbc_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;

   localparam int SAMPLE_W = 32;
   localparam int PROB_W   = 17;
   localparam int FRAC_W   = 16;
   localparam int CAT_W    = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [PROB_W-1:0] PROB_ONE        = 17'd65536;
   localparam logic [PROB_W-1:0] LOWER_PROB_RST  = 17'd3277;
   localparam logic [PROB_W-1:0] UPPER_PROB_RST  = 17'd62259;

   localparam logic [CSR_IDX_W-1:0] REG_LOWER_PROB = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_PROB = 1'b1;

   localparam logic [CAT_W-1:0] CAT_MIDDLE = 2'd0;
   localparam logic [CAT_W-1:0] CAT_LOWER  = 2'd1;
   localparam logic [CAT_W-1:0] CAT_UPPER  = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } chain_ctl_type;

endpackage

FILE: rtl/qbc_cell.sv
module qbc_cell
   import qbc_pkg::*;
#(
   parameter int CNT_W = 11,
   parameter int IDX   = 0
) (
   input  logic          clock,
   input  chain_ctl_type ctl,
   input  sample_type    sample,
   input  logic [CNT_W-1:0] count,
   input  sample_type    prev_val,
   input  logic          prev_gt,
   input  sample_type    next_val,
   output sample_type    val,
   output logic          gt
);

   sample_type val_ff;
   sample_type val_in;
   logic       occ;

   assign occ = count > CNT_W'(IDX);
   assign gt  = occ && (val_ff > sample);
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctl.shift) begin
         val_in = next_val;
      end else if (ctl.insert) begin
         if (prev_gt) begin
            val_in = prev_val;
         end else if (gt || !occ) begin
            val_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

FILE: rtl/qbc_chain.sv
module qbc_chain
   import qbc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
   input  logic             clock,
   input  chain_ctl_type    ctl,
   input  sample_type       sample,
   input  logic [CNT_W-1:0] count,
   output sample_type       head
);

   sample_type vals [MAX_SAMPLES];
   logic       gts  [MAX_SAMPLES];

   assign head = vals[0];

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      sample_type prev_v;
      logic       prev_g;
      sample_type next_v;

      if (i == 0) begin : g_first
         assign prev_v = sample;
         assign prev_g = 1'b0;
      end else begin : g_mid
         assign prev_v = vals[i-1];
         assign prev_g = gts[i-1];
      end

      if (i == MAX_SAMPLES - 1) begin : g_end
         assign next_v = vals[i];
      end else begin : g_inner
         assign next_v = vals[i+1];
      end

      qbc_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .sample   (sample),
         .count    (count),
         .prev_val (prev_v),
         .prev_gt  (prev_g),
         .next_val (next_v),
         .val      (vals[i]),
         .gt       (gts[i])
      );
   end

endmodule

FILE: rtl/quantile_band_classifier.sv
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_sample, req_observed, req_last
// rsp       out        rsp_valid/stall    rsp_category, rsp_overflow
// csr       in         csr_we             csr_index, csr_wdata
//
// a sample without last is inserted into the sorting chain when it is taken
// for an item with last the result becomes valid after the index, drain,
// multiply and sum states: the chain is shifted out one cell per cycle to pick the
// quantile neighbors
// req_stall is high from the last item until its result is taken
// synchronous reset clears the fill count, overflow flag and state, and sets the probability registers to defaults
module quantile_band_classifier
   import qbc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_sample,
   input  logic signed [31:0]   req_observed,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CAT_W-1:0]     rsp_category,
   output logic                 rsp_overflow,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PROB_W-1:0]    csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int POS_W  = IDX_W + PROB_W;
   localparam int PROD_W = FRAC_W + SAMPLE_W;
   localparam int Q_W    = SAMPLE_W + 2;

   typedef enum logic [5:0] {
      ST_COLLECT = 6'b000001,
      ST_INDEX   = 6'b000010,
      ST_DRAIN   = 6'b000100,
      ST_MULT    = 6'b001000,
      ST_SUM     = 6'b010000,
      ST_RESP    = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [PROB_W-1:0]    lprob_ff, lprob_in;
   logic [PROB_W-1:0]    uprob_ff, uprob_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   sample_type           obs_ff, obs_in;
   logic [IDX_W-1:0]     llo_ff, llo_in, lhi_ff, lhi_in;
   logic [IDX_W-1:0]     ulo_ff, ulo_in, uhi_ff, uhi_in;
   logic [FRAC_W-1:0]    lfrac_ff, lfrac_in, ufrac_ff, ufrac_in;
   sample_type           ylo_l_ff, ylo_l_in, yhi_l_ff, yhi_l_in;
   sample_type           ylo_u_ff, ylo_u_in, yhi_u_ff, yhi_u_in;
   logic [PROD_W-1:0]    lprod_ff, lprod_in, uprod_ff, uprod_in;
   logic [CAT_W-1:0]     cat_ff, cat_in;

   chain_ctl_type        ctl;
   sample_type           head;
   logic                 accept;
   logic                 room;
   logic [IDX_W-1:0]     nm1;
   logic [PROB_W-1:0]    lp_sat, up_sat;
   logic [POS_W-1:0]     lpos, upos;
   logic [SAMPLE_W-1:0]  ldiff, udiff;
   logic [Q_W-1:0]       qlo, qhi, obs_x;

   qbc_chain #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock  (clock),
      .ctl    (ctl),
      .sample (req_sample),
      .count  (cnt_ff),
      .head   (head)
   );

   assign req_stall = (state_ff != ST_COLLECT);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_category = cat_ff;
   assign rsp_overflow = ovf_ff;

   assign accept = req_valid && !req_stall;
   assign room   = cnt_ff < CNT_W'(MAX_SAMPLES);
   assign ctl.insert = accept && room;
   assign ctl.shift  = (state_ff == ST_DRAIN);

   assign nm1    = IDX_W'(cnt_ff - CNT_W'(1));
   assign lp_sat = (lprob_ff > PROB_ONE) ? PROB_ONE : lprob_ff;
   assign up_sat = (uprob_ff > PROB_ONE) ? PROB_ONE : uprob_ff;
   assign lpos   = POS_W'(nm1) * POS_W'(lp_sat);
   assign upos   = POS_W'(nm1) * POS_W'(up_sat);

   assign ldiff = SAMPLE_W'({yhi_l_ff[31], yhi_l_ff} - {ylo_l_ff[31], ylo_l_ff});
   assign udiff = SAMPLE_W'({yhi_u_ff[31], yhi_u_ff} - {ylo_u_ff[31], ylo_u_ff});

   assign qlo   = {{2{ylo_l_ff[31]}}, ylo_l_ff} + {2'b00, lprod_ff[PROD_W-1:FRAC_W]};
   assign qhi   = {{2{ylo_u_ff[31]}}, ylo_u_ff} + {2'b00, uprod_ff[PROD_W-1:FRAC_W]};
   assign obs_x = {{2{obs_ff[31]}}, obs_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      lprob_in = lprob_ff;
      uprob_in = uprob_ff;
      k_in     = k_ff;
      obs_in   = obs_ff;
      llo_in   = llo_ff;
      lhi_in   = lhi_ff;
      ulo_in   = ulo_ff;
      uhi_in   = uhi_ff;
      lfrac_in = lfrac_ff;
      ufrac_in = ufrac_ff;
      ylo_l_in = ylo_l_ff;
      yhi_l_in = yhi_l_ff;
      ylo_u_in = ylo_u_ff;
      yhi_u_in = yhi_u_ff;
      lprod_in = lprod_ff;
      uprod_in = uprod_ff;
      cat_in   = cat_ff;

      if (csr_we) begin
         case (csr_index)
            REG_LOWER_PROB: lprob_in = csr_wdata;
            REG_UPPER_PROB: uprob_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (room) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  obs_in   = req_observed;
                  state_in = ST_INDEX;
               end
            end
         end
         ST_INDEX: begin
            llo_in   = lpos[FRAC_W +: IDX_W];
            lfrac_in = lpos[FRAC_W-1:0];
            lhi_in   = lpos[FRAC_W +: IDX_W] + IDX_W'(lpos[FRAC_W-1:0] != '0);
            ulo_in   = upos[FRAC_W +: IDX_W];
            ufrac_in = upos[FRAC_W-1:0];
            uhi_in   = upos[FRAC_W +: IDX_W] + IDX_W'(upos[FRAC_W-1:0] != '0);
            k_in     = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (k_ff == llo_ff) ylo_l_in = head;
            if (k_ff == lhi_ff) yhi_l_in = head;
            if (k_ff == ulo_ff) ylo_u_in = head;
            if (k_ff == uhi_ff) yhi_u_in = head;
            k_in = k_ff + IDX_W'(1);
            if (k_ff == nm1) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            lprod_in = PROD_W'(lfrac_ff) * PROD_W'(ldiff);
            uprod_in = PROD_W'(ufrac_ff) * PROD_W'(udiff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if ($signed(obs_x) >= $signed(qhi)) begin
               cat_in = CAT_UPPER;
            end else if ($signed(obs_x) <= $signed(qlo)) begin
               cat_in = CAT_LOWER;
            end else begin
               cat_in = CAT_MIDDLE;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         lprob_ff <= LOWER_PROB_RST;
         uprob_ff <= UPPER_PROB_RST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         lprob_ff <= lprob_in;
         uprob_ff <= uprob_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      obs_ff   <= obs_in;
      llo_ff   <= llo_in;
      lhi_ff   <= lhi_in;
      ulo_ff   <= ulo_in;
      uhi_ff   <= uhi_in;
      lfrac_ff <= lfrac_in;
      ufrac_ff <= ufrac_in;
      ylo_l_ff <= ylo_l_in;
      yhi_l_ff <= yhi_l_in;
      ylo_u_ff <= ylo_u_in;
      yhi_u_ff <= yhi_u_in;
      lprod_ff <= lprod_in;
      uprod_ff <= uprod_in;
      cat_ff   <= cat_in;
   end

endmodule
